// ----- rtl/bship_pkg.sv -----
// ----------------------------------------------------------------------------
// bship_pkg: shared types and constants
// Fixed-point widths, lane count, control types and the capped square helper
// for the Burning Ship escape-time block.
// ----------------------------------------------------------------------------
`default_nettype none

package bship_pkg;

  localparam int LANES     = 4;
  localparam int FRAC_BITS = 28;
  localparam int C_W       = 32;
  localparam int CNT_W     = 16;

  // a running |zx|, |zy| stays below 2.0, so it fits in FRAC_BITS+1 bits
  localparam int MAG_W  = FRAC_BITS + 1;
  // squares are capped at 4.0, which needs FRAC_BITS+3 bits
  localparam int SQ_W   = FRAC_BITS + 3;
  localparam int PROD_W = 2 * MAG_W;
  // zx and zy: sum of a bounded term and a C_W-bit input, plus sign
  localparam int Z_W    = ((SQ_W > C_W) ? SQ_W : C_W) + 2;

  localparam logic [SQ_W-1:0] FOUR = SQ_W'(1) << (FRAC_BITS + 2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_RUN
  } ctl_state_t;

  // start token and shared imaginary part, handed from cell to cell
  typedef struct packed {
    logic                  start;
    logic signed [C_W-1:0] ci;
  } chain_link_t;

  // per-cell status seen by the controller
  typedef struct packed {
    logic             done;
    logic             escaped;
    logic [CNT_W-1:0] steps;
  } cell_stat_t;

  // magnitude of a signed z value
  function automatic logic [Z_W-1:0] zmag(input logic signed [Z_W-1:0] v);
    zmag = v[Z_W-1] ? Z_W'(-v) : Z_W'(v);
  endfunction

  // square shifted down by FRAC_BITS, capped at 4.0
  function automatic logic [SQ_W-1:0] sq_cap(input logic signed [Z_W-1:0] v);
    logic [Z_W-1:0]    a;
    logic [PROD_W-1:0] p;
    a = zmag(v);
    p = a[MAG_W-1:0] * a[MAG_W-1:0];
    if ((a >> MAG_W) != '0) begin
      sq_cap = FOUR;
    end else begin
      sq_cap = SQ_W'(p >> FRAC_BITS);
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bship_in_if.sv -----
// ----------------------------------------------------------------------------
// bship_in_if: point channel
// Four real parts of c and one shared imaginary part, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bship_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] c_real_0;
  logic signed [31:0] c_real_1;
  logic signed [31:0] c_real_2;
  logic signed [31:0] c_real_3;
  logic signed [31:0] c_imag;

  modport source (output valid, c_real_0, c_real_1, c_real_2, c_real_3, c_imag,
                  input ready);
  modport sink   (input valid, c_real_0, c_real_1, c_real_2, c_real_3, c_imag,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/bship_out_if.sv -----
// ----------------------------------------------------------------------------
// bship_out_if: result channel
// Step counts and escaped flags for four lanes, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bship_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] steps_0;
  logic [15:0] steps_1;
  logic [15:0] steps_2;
  logic [15:0] steps_3;
  logic        escaped_0;
  logic        escaped_1;
  logic        escaped_2;
  logic        escaped_3;

  modport source (output valid, steps_0, steps_1, steps_2, steps_3,
                  escaped_0, escaped_1, escaped_2, escaped_3, input ready);
  modport sink   (input valid, steps_0, steps_1, steps_2, steps_3,
                  escaped_0, escaped_1, escaped_2, escaped_3, output ready);
endinterface

`default_nettype wire

// ----- rtl/bship_cell.sv -----
// ----------------------------------------------------------------------------
// bship_cell: one lane of the iteration chain
// Runs the Burning Ship iteration for one point, each step split into a cross-product
// phase and a squares phase, and passes the start token and shared imaginary part on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bship_cell
  import bship_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [CNT_W-1:0]      max_iter,
  input  wire logic signed [C_W-1:0] cr,
  input  wire chain_link_t           link_in,
  output chain_link_t                link_out,
  output cell_stat_t                 stat
);

  logic                    busy;
  logic                    phase;
  logic                    done;
  logic                    escaped;
  logic [CNT_W-1:0]        count;
  logic signed [C_W-1:0]   ci;
  logic signed [Z_W-1:0]   zx;
  logic signed [Z_W-1:0]   zy;
  logic [SQ_W-1:0]         sqx;
  logic [SQ_W-1:0]         sqy;
  logic [SQ_W-1:0]         prod;

  logic [Z_W-1:0]          ax;
  logic [Z_W-1:0]          ay;
  logic [PROD_W-1:0]       prod_full;
  logic signed [Z_W-1:0]   zx_next;
  logic signed [Z_W-1:0]   zy_next;
  logic [SQ_W-1:0]         sqx_next;
  logic [SQ_W-1:0]         sqy_next;
  logic                    hit;
  logic [CNT_W:0]          count_inc;

  // phase 0: cross product and new zx
  assign ax        = zmag(zx);
  assign ay        = zmag(zy);
  assign prod_full = ax[MAG_W-1:0] * ay[MAG_W-1:0];
  assign zx_next   = $signed(Z_W'(sqx)) - $signed(Z_W'(sqy))
                   + $signed({{(Z_W-C_W){cr[C_W-1]}}, cr});

  // phase 1: new zy, squares and escape test
  assign zy_next   = $signed(Z_W'(prod)) + $signed({{(Z_W-C_W){ci[C_W-1]}}, ci});
  assign sqx_next  = sq_cap(zx);
  assign sqy_next  = sq_cap(zy_next);
  assign hit       = ({1'b0, sqx_next} + {1'b0, sqy_next}) >= {1'b0, FOUR};
  assign count_inc = {1'b0, count} + (CNT_W+1)'(1);

  // chain link register
  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.start <= 1'b0;
    end else begin
      link_out.start <= link_in.start;
    end
    link_out.ci <= link_in.ci;
  end

  // lane control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      phase   <= 1'b0;
      escaped <= 1'b0;
      count   <= '0;
    end else if (link_in.start) begin
      phase   <= 1'b0;
      escaped <= 1'b0;
      count   <= '0;
      busy    <= (max_iter != '0);
      done    <= (max_iter == '0);
    end else if (busy) begin
      phase <= ~phase;
      if (phase) begin
        if (hit) begin
          escaped <= 1'b1;
          busy    <= 1'b0;
          done    <= 1'b1;
        end else begin
          count <= count_inc[CNT_W-1:0];
          if (count_inc == {1'b0, max_iter}) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  // iteration datapath
  always_ff @(posedge clk) begin
    if (link_in.start) begin
      ci  <= link_in.ci;
      zx  <= '0;
      zy  <= '0;
      sqx <= '0;
      sqy <= '0;
    end else if (busy) begin
      if (!phase) begin
        prod <= SQ_W'(prod_full >> (FRAC_BITS - 1));
        zx   <= zx_next;
      end else begin
        zy  <= zy_next;
        sqx <= sqx_next;
        sqy <= sqy_next;
      end
    end
  end

  assign stat.done    = done;
  assign stat.escaped = escaped;
  assign stat.steps   = count;

endmodule

`default_nettype wire

// ----- rtl/burning_ship_escape_time.sv -----
// ----------------------------------------------------------------------------
// burning_ship_escape_time: four-lane Burning Ship escape-time engine
// Controller, configuration register, output register and the cell chain.
// ----------------------------------------------------------------------------
// Each accepted word carries four points sharing one imaginary part. Every
// lane has its own cell that splits each iteration step into a cross-product
// phase and a phase for the squares and escape test, so a word ends sooner
// when all lanes escape early. The start token ripples down the chain
// one cell per cycle. A new word is accepted once the previous one is
// finished; its result sits in an output register until taken. The
// iteration limit resets to 256 and must only be written while the block
// is idle.
`default_nettype none

module burning_ship_escape_time
  import bship_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  bship_in_if.sink         points,
  bship_out_if.source      results
);

  ctl_state_t            state;
  ctl_state_t            state_next;
  logic [CNT_W-1:0]      max_iter;
  logic signed [C_W-1:0] cr [LANES];
  logic signed [C_W-1:0] ci;
  logic                  launch;
  logic                  load_out;
  logic                  out_valid;
  logic [CNT_W-1:0]      steps_q [LANES];
  logic                  esc_q [LANES];
  logic                  all_done;
  logic                  accept;

  chain_link_t           link [LANES+1];
  cell_stat_t            stat [LANES];

  assign accept = points.valid && points.ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter <= CNT_W'(256);
    end else if (cfg_we) begin
      max_iter <= cfg_wdata;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cr[0] <= points.c_real_0;
      cr[1] <= points.c_real_1;
      cr[2] <= points.c_real_2;
      cr[3] <= points.c_real_3;
      ci    <= points.c_imag;
    end
  end

  // cell chain
  assign link[0].start = launch;
  assign link[0].ci    = ci;

  for (genvar i = 0; i < LANES; i++) begin : g_cell
    bship_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .max_iter (max_iter),
      .cr       (cr[i]),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .stat     (stat[i])
    );
  end

  always_comb begin
    all_done = 1'b1;
    for (int i = 0; i < LANES; i++) begin
      all_done = all_done & stat[i].done;
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_LAUNCH;
      ST_LAUNCH: if (link[LANES].start) state_next = ST_RUN;
      ST_RUN:    if (all_done && (!out_valid || results.ready)) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    points.ready = 1'b0;
    load_out     = 1'b0;
    case (state)
      ST_IDLE:   points.ready = 1'b1;
      ST_LAUNCH: ;
      ST_RUN:    load_out = all_done && (!out_valid || results.ready);
      default:   ;
    endcase
  end

  // launch pulse in the cycle after accept
  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= 1'b0;
    end else begin
      launch <= accept;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      for (int i = 0; i < LANES; i++) begin
        steps_q[i] <= stat[i].steps;
        esc_q[i]   <= stat[i].escaped;
      end
    end
  end

  assign results.valid     = out_valid;
  assign results.steps_0   = steps_q[0];
  assign results.steps_1   = steps_q[1];
  assign results.steps_2   = steps_q[2];
  assign results.steps_3   = steps_q[3];
  assign results.escaped_0 = esc_q[0];
  assign results.escaped_1 = esc_q[1];
  assign results.escaped_2 = esc_q[2];
  assign results.escaped_3 = esc_q[3];

  // an accepted word always launches the chain
  a_launch: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_LAUNCH) && launch)
    else $error("accepted word did not launch");

  // a lane never reports more steps than allowed
  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (steps_q[0] <= max_iter) && (steps_q[1] <= max_iter)
               && (steps_q[2] <= max_iter) && (steps_q[3] <= max_iter))
    else $error("step count above iteration limit");

  // lane 0, if it did not escape, ran the full count
  a_full_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !esc_q[0]) |-> (steps_q[0] == max_iter))
    else $error("lane 0 stopped early without escape");

endmodule

`default_nettype wire
